### hw/rtl/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
package utf8d_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int ERR_POS_BITS          = 32;
    localparam int CP_BITS               = 21;

    // Lead and continuation byte ranges
    localparam logic [7:0] ASCII_MAX   = 8'h7f;
    localparam logic [7:0] LEAD2_MIN   = 8'hc2;
    localparam logic [7:0] LEAD2_MAX   = 8'hdf;
    localparam logic [7:0] LEAD3_MIN   = 8'he0;
    localparam logic [7:0] LEAD3_MAX   = 8'hef;
    localparam logic [7:0] LEAD4_MIN   = 8'hf0;
    localparam logic [7:0] LEAD4_MAX   = 8'hf4;
    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_MAX    = 8'hbf;
    localparam logic [7:0] CONT_MASK   = 8'h3f;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef enum logic [2:0] {
        KIND_CODE_POINT = 3'd0,
        KIND_END        = 3'd1,
        KIND_BAD_LEAD   = 3'd2,
        KIND_BAD_CONT   = 3'd3,
        KIND_TRUNCATED  = 3'd4
    } result_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        result_kind_t               result_kind;
        logic [CP_BITS-1:0]         scalar_value;
        logic [ERR_POS_BITS-1:0]    error_position;
        logic [7:0]                 offending_byte;
        logic [2:0]                 expected_length;
    } out_item_t;

endpackage

### hw/rtl/utf8_stream_decoder.sv
// utf8_stream_decoder: UTF-8 byte stream to code point decoder, top level.
// A byte waits in the input register; its result is then held in the result register.
// Throughput: one byte per cycle, unless a full result register meets m_ready low.
// Multi-byte leads and inner continuation bytes give no result transaction.
// Reset (aresetn low, synchronous): both stages empty, decoder idle, position zero.
// Depends on utf8d_pkg, utf8d_in_stage, utf8d_decode, utf8d_out_stage.
module utf8_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      item_valid;
    in_item_t  item;
    logic      out_free;
    logic      advance;
    logic      res_valid;
    out_item_t res_item;

    // A held byte moves through the decoder whenever the result slot is free
    // or is being emptied in the same cycle; this keeps one byte per cycle.
    assign advance = item_valid && out_free;

    utf8d_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Sequence state only updates on advance, so a stalled byte is not
    // decoded twice.
    utf8d_decode #(
        .POSITION_BITS (POSITION_BITS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    utf8d_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_valid (res_valid),
        .load_item  (res_item),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

### hw/rtl/utf8d_in_stage.sv
// utf8d_in_stage: input register for byte transactions.
// Depends on utf8d_pkg (in_item_t).
module utf8d_in_stage
    import utf8d_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### hw/rtl/utf8d_decode.sv
// utf8d_decode: sequence state and per-byte decode logic.
// Depends on utf8d_pkg (item types, byte ranges, result kinds).
module utf8d_decode
    import utf8d_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res_item
);

    logic [1:0]               remaining_reg, remaining_next;
    logic [2:0]               seq_len_reg, seq_len_next;
    logic [CP_BITS-1:0]       acc_reg, acc_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic [7:0]               b;
    logic [2:0]               bad_idx;
    logic [CP_BITS-1:0]       acc_shift;
    logic [POSITION_BITS-1:0] pos_sel;
    logic [ERR_POS_BITS-1:0]  pos_err;

    assign b         = item.data_byte;
    assign bad_idx   = seq_len_reg - {1'b0, remaining_reg};
    assign acc_shift = {acc_reg[CP_BITS-7:0], b[5:0] & CONT_MASK[5:0]};

    // Reported position: plain counter, or counter plus index of a bad
    // continuation byte (truncation reports the plain counter)
    assign pos_sel = (remaining_reg != 2'd0 && !item.end_of_input) ?
                     pos_reg + POSITION_BITS'(bad_idx) : pos_reg;

    generate
        if (POSITION_BITS >= ERR_POS_BITS) begin : g_pos_trunc
            assign pos_err = pos_sel[ERR_POS_BITS-1:0];
        end else begin : g_pos_ext
            assign pos_err = {{(ERR_POS_BITS-POSITION_BITS){1'b0}}, pos_sel};
        end
    endgenerate

    always_comb begin
        remaining_next = remaining_reg;
        seq_len_next   = seq_len_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        res_valid      = 1'b0;
        res_item       = '0;

        if (remaining_reg == 2'd0) begin
            if (item.end_of_input) begin
                res_valid            = 1'b1;
                res_item.result_kind = KIND_END;
            end else begin
                case (b) inside
                    [8'h00:ASCII_MAX]: begin
                        pos_next              = pos_reg + POSITION_BITS'(1);
                        res_valid             = 1'b1;
                        res_item.result_kind  = KIND_CODE_POINT;
                        res_item.scalar_value = CP_BITS'(b);
                    end
                    [LEAD2_MIN:LEAD2_MAX]: begin
                        seq_len_next   = SEQ_LEN2;
                        remaining_next = 2'd1;
                        acc_next       = CP_BITS'(b[4:0]);
                    end
                    [LEAD3_MIN:LEAD3_MAX]: begin
                        seq_len_next   = SEQ_LEN3;
                        remaining_next = 2'd2;
                        acc_next       = CP_BITS'(b[3:0]);
                    end
                    [LEAD4_MIN:LEAD4_MAX]: begin
                        seq_len_next   = SEQ_LEN4;
                        remaining_next = 2'd3;
                        acc_next       = CP_BITS'(b[2:0]);
                    end
                    default: begin
                        res_valid               = 1'b1;
                        res_item.result_kind    = KIND_BAD_LEAD;
                        res_item.error_position = pos_err;
                        res_item.offending_byte = b;
                    end
                endcase
            end
        end else if (item.end_of_input) begin
            remaining_next           = 2'd0;
            seq_len_next             = 3'd0;
            acc_next                 = '0;
            res_valid                = 1'b1;
            res_item.result_kind     = KIND_TRUNCATED;
            res_item.error_position  = pos_err;
            res_item.expected_length = seq_len_reg;
        end else if (b < CONT_MIN || b > CONT_MAX) begin
            remaining_next          = 2'd0;
            seq_len_next            = 3'd0;
            acc_next                = '0;
            res_valid               = 1'b1;
            res_item.result_kind    = KIND_BAD_CONT;
            res_item.error_position = pos_err;
            res_item.offending_byte = b;
        end else if (remaining_reg == 2'd1) begin
            remaining_next        = 2'd0;
            seq_len_next          = 3'd0;
            acc_next              = '0;
            pos_next              = pos_reg + POSITION_BITS'(seq_len_reg);
            res_valid             = 1'b1;
            res_item.result_kind  = KIND_CODE_POINT;
            res_item.scalar_value = acc_shift;
        end else begin
            remaining_next = remaining_reg - 2'd1;
            acc_next       = acc_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg <= 2'd0;
            seq_len_reg   <= 3'd0;
            acc_reg       <= '0;
            pos_reg       <= '0;
        end else if (advance) begin
            remaining_reg <= remaining_next;
            seq_len_reg   <= seq_len_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

### hw/rtl/utf8d_out_stage.sv
// utf8d_out_stage: result register on the output channel.
// Depends on utf8d_pkg (out_item_t).
module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  logic      load_valid,
    input  out_item_t load_item,
    output logic      free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        if (load) begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && load_valid) begin
            item_reg <= load_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

### hw/rtl/utf8d_checker.sv
// utf8d_checker: port-level assertions on result transactions, bound to the top.
// Depends on utf8d_pkg and utf8_stream_decoder.
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_cp_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == KIND_CODE_POINT |->
        m_item.error_position == '0 && m_item.offending_byte == 8'h00 &&
        m_item.expected_length == 3'd0)
        else $error("code point carries error fields");

    a_trunc_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == KIND_TRUNCATED |->
        (m_item.expected_length == SEQ_LEN2 || m_item.expected_length == SEQ_LEN3 ||
         m_item.expected_length == SEQ_LEN4) && m_item.scalar_value == '0)
        else $error("bad truncated length");

    a_bad_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.result_kind == KIND_BAD_LEAD |->
        (m_item.offending_byte >= CONT_MIN && m_item.offending_byte < LEAD2_MIN) ||
        m_item.offending_byte > LEAD4_MAX)
        else $error("valid lead reported as bad");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

### dv/utf8_stream_decoder_test.sv
// utf8_stream_decoder_test: self-checking testbench for the UTF-8 stream decoder.
// Predicts every result transaction in-line and scoreboards the m_ channel in order.
// Depends on utf8d_pkg and utf8_stream_decoder; needs no files or arguments.
module utf8_stream_decoder_test;
    import utf8d_pkg::*;

    // One queued byte transaction. hold_for_drain makes the driver wait until
    // every predicted result has been seen before presenting it.
    typedef struct {
        in_item_t item;
        bit       hold_for_drain;
    } byte_stim_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    utf8_stream_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Pending byte transactions, filled by the stimulus process.
    byte_stim_t byte_q[$];
    // Results the decoder owes us, oldest first.
    out_item_t  decoded_expect[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_queued   = 0;
    logic        byte_taken     = 1'b0;

    // Shadow decoder state
    logic [1:0]  dec_rem = '0;   // continuation bytes still due, 0 = idle
    logic [2:0]  dec_len = '0;   // length of the open sequence
    logic [20:0] dec_acc = '0;   // payload bits gathered so far
    logic [31:0] dec_pos = '0;   // byte position, advances on decoded code points only

    // Scoreboard counters
    int unsigned mismatches    = 0;
    int unsigned bytes_taken   = 0;
    int unsigned n_scalars     = 0;
    int unsigned n_errors      = 0;
    int unsigned n_end_marks   = 0;

    byte_stim_t next_stim;

    // ------------------------------------------------------------------
    // Shadow decoder: advance state for one accepted byte transaction and
    // queue the result it produces, if any.
    // ------------------------------------------------------------------
    task automatic decode_transaction(input in_item_t it);
        out_item_t  r;
        logic [7:0] b;
        logic [2:0] idx;
        b = it.data_byte;
        r = '0;
        if (dec_rem == 2'd0) begin
            if (it.end_of_input) begin
                // end marker while idle: report it, state untouched
                r.result_kind = KIND_END;
                decoded_expect.push_back(r);
            end else if (b <= ASCII_MAX) begin
                dec_pos        = dec_pos + 32'd1;
                r.scalar_value = {13'd0, b};
                decoded_expect.push_back(r);
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                dec_len = SEQ_LEN2;
                dec_acc = {16'd0, b[4:0]};
                dec_rem = 2'd1;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                dec_len = SEQ_LEN3;
                dec_acc = {17'd0, b[3:0]};
                dec_rem = 2'd2;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                dec_len = SEQ_LEN4;
                dec_acc = {18'd0, b[2:0]};
                dec_rem = 2'd3;
            end else begin
                // bad lead is consumed; decoder stays idle, position frozen
                r.result_kind    = KIND_BAD_LEAD;
                r.error_position = dec_pos;
                r.offending_byte = b;
                decoded_expect.push_back(r);
            end
        end else if (it.end_of_input) begin
            // stream ended mid-sequence
            r.result_kind     = KIND_TRUNCATED;
            r.error_position  = dec_pos;
            r.expected_length = dec_len;
            dec_rem = '0;
            dec_len = '0;
            dec_acc = '0;
            decoded_expect.push_back(r);
        end else if (b < CONT_MIN || b > CONT_MAX) begin
            // position points at the bad byte inside its sequence (1..3);
            // the byte is dropped, not retried as a lead
            idx = dec_len - {1'b0, dec_rem};
            r.result_kind    = KIND_BAD_CONT;
            r.error_position = dec_pos + {29'd0, idx};
            r.offending_byte = b;
            dec_rem = '0;
            dec_len = '0;
            dec_acc = '0;
            decoded_expect.push_back(r);
        end else begin
            dec_acc = {dec_acc[14:0], b[5:0]};
            dec_rem = dec_rem - 2'd1;
            if (dec_rem == 2'd0) begin
                r.scalar_value = dec_acc;
                dec_pos = dec_pos + {29'd0, dec_len};
                dec_len = '0;
                dec_acc = '0;
                decoded_expect.push_back(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Rising edge: note s_ transactions, run the shadow decoder on them,
    // then score any m_ transaction. Prediction goes first so the order of
    // the two never depends on the decoder's latency.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        byte_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            bytes_taken++;
            decode_transaction(s_item);
        end
        if (aresetn && m_valid && m_ready) begin
            case (m_item.result_kind)
                KIND_CODE_POINT: n_scalars++;
                KIND_END:        n_end_marks++;
                default:         n_errors++;
            endcase
            if (decoded_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d cp %h pos %h byte %h len %0d",
                             m_item.result_kind, m_item.scalar_value,
                             m_item.error_position, m_item.offending_byte,
                             m_item.expected_length);
                end
            end else begin
                if (m_item.result_kind     !== decoded_expect[0].result_kind ||
                    m_item.scalar_value    !== decoded_expect[0].scalar_value ||
                    m_item.error_position  !== decoded_expect[0].error_position ||
                    m_item.offending_byte  !== decoded_expect[0].offending_byte ||
                    m_item.expected_length !== decoded_expect[0].expected_length) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch (exp/act): kind %0d/%0d cp %h/%h pos %h/%h",
                               decoded_expect[0].result_kind, m_item.result_kind,
                               decoded_expect[0].scalar_value, m_item.scalar_value,
                               decoded_expect[0].error_position, m_item.error_position);
                        $display(" byte %h/%h len %0d/%0d",
                                 decoded_expect[0].offending_byte, m_item.offending_byte,
                                 decoded_expect[0].expected_length,
                                 m_item.expected_length);
                    end
                end
                void'(decoded_expect.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: moves on the falling edge. A new byte is presented only once
    // the current one has been taken (or none is up); a drain-marked byte
    // waits for the scoreboard to empty.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || byte_taken)) begin
            if (byte_q.size() != 0 &&
                (!byte_q[0].hold_for_drain || decoded_expect.size() == 0) &&
                $urandom_range(99) >= send_idle_pct) begin
                next_stim = byte_q.pop_front();
                s_item  <= next_stim.item;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [7:0] b, input bit eoi, input bit drain);
        byte_stim_t s;
        s.item.data_byte    = b;
        s.item.end_of_input = eoi;
        s.hold_for_drain    = drain;
        byte_q.push_back(s);
        bytes_queued++;
    endtask

    function automatic logic [7:0] lead_byte(input int unsigned len);
        case (len)
            1:       return 8'($urandom_range(0, 127));
            2:       return 8'($urandom_range(32'hc2, 32'hdf));
            3:       return 8'($urandom_range(32'he0, 32'hef));
            default: return 8'($urandom_range(32'hf0, 32'hf4));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(32'h80, 32'hbf));
    endfunction

    // anything outside 80-BF
    function automatic logic [7:0] non_cont_byte();
        if ($urandom_range(1) == 0) begin
            return 8'($urandom_range(0, 127));
        end
        return 8'($urandom_range(32'hc0, 32'hff));
    endfunction

    // One random chunk: mostly well-formed code points, some noise and
    // sequences broken by a bad continuation or an end marker.
    task automatic add_random_chunk();
        int unsigned sel;
        int unsigned len;
        int unsigned good;
        bit          drain;
        sel   = $urandom_range(99);
        drain = ($urandom_range(99) < 2);
        len   = $urandom_range(1, 4);
        if (sel < 65) begin
            add_item(lead_byte(len), 1'b0, drain);
            for (int i = 1; i < len; i++) add_item(cont_byte(), 1'b0, 1'b0);
        end else if (sel < 75) begin
            add_item(8'($urandom_range(255)), 1'b0, drain);
        end else if (sel < 87) begin
            len  = $urandom_range(2, 4);
            good = $urandom_range(0, len - 2);
            add_item(lead_byte(len), 1'b0, drain);
            for (int i = 0; i < good; i++) add_item(cont_byte(), 1'b0, 1'b0);
            if ($urandom_range(2) == 0) begin
                add_item(8'($urandom_range(255)), 1'b1, 1'b0);
            end else begin
                add_item(non_cont_byte(), 1'b0, 1'b0);
            end
        end else if (sel < 93) begin
            add_item(8'($urandom_range(255)), 1'b1, drain);
        end else begin
            add_item(8'($urandom_range(255)), 1'($urandom_range(1)), drain);
        end
    endtask

    task automatic drain_byte_queue();
        while (byte_q.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed bytes, then four random phases with varied idling.
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: ASCII extremes, 2/3/4-byte extremes, bad leads,
        // bad continuation at first and last index, end idle and mid-sequence
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h7f, 1'b0, 1'b0);
        add_item(8'hdf, 1'b0, 1'b0);
        add_item(8'hbf, 1'b0, 1'b0);
        add_item(8'he0, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'hf4, 1'b0, 1'b0);
        add_item(8'hbf, 1'b0, 1'b0);
        add_item(8'hbf, 1'b0, 1'b0);
        add_item(8'hbf, 1'b0, 1'b0);
        add_item(8'hc2, 1'b0, 1'b0);
        add_item(8'h7f, 1'b0, 1'b0);   // bad continuation, not retried as ASCII
        add_item(8'hf0, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'hff, 1'b0, 1'b0);   // bad continuation at the last index
        add_item(8'h80, 1'b0, 1'b0);   // stray continuation as lead
        add_item(8'hc1, 1'b0, 1'b0);
        add_item(8'hf5, 1'b0, 1'b0);
        add_item(8'hff, 1'b1, 1'b0);   // end while idle, byte ignored
        add_item(8'he0, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);   // truncated 3-byte sequence
        add_item(8'h41, 1'b0, 1'b0);   // decoding goes on after the end marker

        while (bytes_queued < 300) add_random_chunk();
        drain_byte_queue();

        send_idle_pct = 45;
        add_item(8'h24, 1'b0, 1'b1);
        while (bytes_queued < 580) add_random_chunk();
        drain_byte_queue();

        send_idle_pct  = 0;
        recv_stall_pct = 45;
        add_item(8'hc3, 1'b0, 1'b1);
        add_item(8'ha9, 1'b0, 1'b0);
        while (bytes_queued < 860) add_random_chunk();
        drain_byte_queue();

        send_idle_pct  = 37;
        recv_stall_pct = 37;
        while (bytes_queued < 1150) add_random_chunk();
        drain_byte_queue();

        while (s_valid) @(posedge aclk);
        while (decoded_expect.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d byte transactions: %0d code points, %0d errors, %0d end markers",
                 bytes_taken, n_scalars, n_errors, n_end_marks);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("** utf8_stream_decoder: PASSED **");
        end else begin
            $display("** utf8_stream_decoder: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #400000;
        $display("timeout, %0d results still awaited", decoded_expect.size());
        $display("** utf8_stream_decoder: FAILED **");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8d_in_stage.sv
hw/rtl/utf8d_decode.sv
hw/rtl/utf8d_out_stage.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/utf8d_checker.sv
dv/utf8_stream_decoder_test.sv
